FILE: hw/rtl/vss_pkg.sv
// Package for the vector similarity scorer.
// Holds the channel word types, field widths, register indexes and metric codes.
// No dependencies.
`timescale 1ns / 1ps

package vss_pkg;

  localparam int ELEM_W  = 16;  // element width, signed Q1.15
  localparam int ACC_W   = 48;  // accumulator and score width
  localparam int ROW_W   = 16;  // row number width
  localparam int DIM_W   = 9;   // dimension register width
  localparam int MET_W   = 2;   // metric register width
  localparam int APB_AW  = 3;   // byte address width of the register port
  localparam int APB_DW  = 32;

  // register index, taken from paddr[2]
  localparam logic REG_METRIC    = 1'b0;
  localparam logic REG_DIMENSION = 1'b1;

  localparam logic [MET_W-1:0] METRIC_DOT  = 2'd0;
  localparam logic [MET_W-1:0] METRIC_DIST = 2'd1;
  localparam logic [MET_W-1:0] METRIC_NORM = 2'd2;

  localparam logic MODE_QUERY = 1'b0;
  localparam logic MODE_ROW   = 1'b1;

  typedef struct packed {
    logic                     mode;
    logic signed [ELEM_W-1:0] element;
  } in_word_t;

  typedef struct packed {
    logic signed [ACC_W-1:0] score;
    logic        [ROW_W-1:0] row_number;
  } out_word_t;

endpackage

FILE: hw/rtl/vector_similarity_scorer.sv
// Pipeline: a row's last element passes stage 1, stage 2 and the output register before it leaves as a result word.
// Throughput: one element word per cycle; in_stall is high only while a result
// waits in the output register with out_stall high.
// Query store: one synchronous RAM, read and written at the accepting edge.
// Reset (rst_n low, synchronous): clears control, registers and the store's valid
// bits, so every query entry reads as zero until loaded; no clearing pass.
`timescale 1ns / 1ps

module vector_similarity_scorer #(
  parameter int MAX_DIM = 256
) (
  input  logic                            clk,
  input  logic                            rst_n,
  input  logic                            in_valid,
  output logic                            in_stall,
  input  vss_pkg::in_word_t               in_word,
  output logic                            out_valid,
  input  logic                            out_stall,
  output vss_pkg::out_word_t              out_word,
  input  logic                            psel,
  input  logic                            penable,
  input  logic                            pwrite,
  input  logic [vss_pkg::APB_AW-1:0]      paddr,
  input  logic [vss_pkg::APB_DW-1:0]      pwdata,
  output logic [vss_pkg::APB_DW-1:0]      prdata,
  output logic                            pready
);
  import vss_pkg::*;

  localparam int AW = (MAX_DIM > 1) ? $clog2(MAX_DIM) : 1;
  localparam int PW = 2 * ELEM_W + 2;  // product width

  // configuration
  logic [MET_W-1:0] metric_r;
  logic [DIM_W-1:0] dimension_r;
  logic             cfg_wr;
  logic [AW:0]      dim_eff;

  assign pready = 1'b1;
  assign cfg_wr = psel && penable && pwrite && pready;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      metric_r    <= METRIC_DOT;
      dimension_r <= DIM_W'(256);
    end else if (cfg_wr) begin
      unique case (paddr[2])
        REG_METRIC:    metric_r    <= pwdata[MET_W-1:0];
        REG_DIMENSION: dimension_r <= pwdata[DIM_W-1:0];
        default: ;
      endcase
    end
  end

  always_comb begin
    unique case (paddr[2])
      REG_METRIC:    prdata = APB_DW'(metric_r);
      REG_DIMENSION: prdata = APB_DW'(dimension_r);
      default:       prdata = '0;
    endcase
  end

  always_comb begin
    if (dimension_r == '0) begin
      dim_eff = (AW+1)'(1);
    end else if (int'(dimension_r) > MAX_DIM) begin
      dim_eff = (AW+1)'(MAX_DIM);
    end else begin
      dim_eff = (AW+1)'(dimension_r);
    end
  end

  // handshake: every stage moves together when the output register can take a word
  logic adv, acc_in, acc_q, acc_row;
  logic out_valid_r;

  assign adv      = !out_valid_r || !out_stall;
  assign in_stall = !adv;
  assign acc_in   = in_valid && adv;
  assign acc_q    = acc_in && (in_word.mode == MODE_QUERY);
  assign acc_row  = acc_in && (in_word.mode == MODE_ROW);

  // positions and row counter
  logic [AW-1:0]    qpos_r, rpos_r;
  logic [AW:0]      qpos_inc, rpos_inc;
  logic [ROW_W-1:0] row_cnt_r;
  logic             row_last;

  assign qpos_inc = (AW+1)'(qpos_r) + (AW+1)'(1);
  assign rpos_inc = (AW+1)'(rpos_r) + (AW+1)'(1);
  assign row_last = (rpos_inc >= dim_eff);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      qpos_r    <= '0;
      rpos_r    <= '0;
      row_cnt_r <= '0;
    end else if (acc_q) begin
      qpos_r    <= (qpos_inc >= dim_eff) ? '0 : qpos_inc[AW-1:0];
      rpos_r    <= '0;
      row_cnt_r <= '0;
    end else if (acc_row) begin
      if (row_last) begin
        rpos_r    <= '0;
        row_cnt_r <= row_cnt_r + ROW_W'(1);
      end else begin
        rpos_r    <= rpos_inc[AW-1:0];
      end
    end
  end

  // query store: RAM plus per-entry valid bits; unloaded entries read as zero
  logic [ELEM_W-1:0] qmem [MAX_DIM];
  logic              qvld_r [MAX_DIM];
  logic [ELEM_W-1:0] qrd_r;
  logic              qrd_vld_r;

  always_ff @(posedge clk) begin
    if (acc_q) begin
      qmem[qpos_r] <= in_word.element;
    end
    if (acc_row) begin
      qrd_r <= qmem[rpos_r];
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      for (int i = 0; i < MAX_DIM; i++) begin
        qvld_r[i] <= 1'b0;
      end
      qrd_vld_r <= 1'b0;
    end else begin
      if (acc_q) begin
        qvld_r[qpos_r] <= 1'b1;
      end
      if (acc_row) begin
        qrd_vld_r <= qvld_r[rpos_r];
      end
    end
  end

  // stage 1: operand select and multiply
  logic                     s1_vld_r, s1_first_r, s1_last_r;
  logic signed [ELEM_W-1:0] s1_x_r;
  logic [ROW_W-1:0]         s1_row_r;
  logic signed [ELEM_W:0]   x_ext, q_ext, diff, op_a, op_b;
  logic signed [PW-1:0]     prod;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_vld_r <= 1'b0;
    end else if (adv) begin
      s1_vld_r <= acc_row;
    end
  end

  always_ff @(posedge clk) begin
    if (acc_row) begin
      s1_x_r     <= in_word.element;
      s1_first_r <= (rpos_r == '0);
      s1_last_r  <= row_last;
      s1_row_r   <= row_cnt_r;
    end
  end

  always_comb begin
    x_ext = {s1_x_r[ELEM_W-1], s1_x_r};
    q_ext = qrd_vld_r ? {qrd_r[ELEM_W-1], qrd_r} : '0;
    diff  = x_ext - q_ext;
    unique case (metric_r)
      METRIC_DIST: begin
        op_a = diff;
        op_b = diff;
      end
      METRIC_NORM: begin
        op_a = x_ext;
        op_b = x_ext;
      end
      default: begin  // dot product, also the unused code
        op_a = x_ext;
        op_b = q_ext;
      end
    endcase
    prod = PW'(op_a) * PW'(op_b);
  end

  // stage 2: product register
  logic                 s2_vld_r, s2_first_r, s2_last_r;
  logic signed [PW-1:0] s2_term_r;
  logic [ROW_W-1:0]     s2_row_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s2_vld_r <= 1'b0;
    end else if (adv) begin
      s2_vld_r <= s1_vld_r;
    end
  end

  always_ff @(posedge clk) begin
    if (adv && s1_vld_r) begin
      s2_term_r  <= prod;
      s2_first_r <= s1_first_r;
      s2_last_r  <= s1_last_r;
      s2_row_r   <= s1_row_r;
    end
  end

  // accumulate; the first element of a row starts from zero
  logic signed [ACC_W-1:0] acc_r, acc_sum;
  out_word_t               out_word_r;

  assign acc_sum = (s2_first_r ? '0 : acc_r)
                 + {{(ACC_W-PW){s2_term_r[PW-1]}}, s2_term_r};

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (adv) begin
      out_valid_r <= s2_vld_r && s2_last_r;
    end
  end

  always_ff @(posedge clk) begin
    if (adv && s2_vld_r) begin
      acc_r <= acc_sum;
      if (s2_last_r) begin
        out_word_r.score      <= acc_sum;
        out_word_r.row_number <= s2_row_r;
      end
    end
  end

  assign out_valid = out_valid_r;
  assign out_word  = out_word_r;

endmodule

FILE: hw/rtl/vss_checker.sv
// Port-level checker for the vector similarity scorer, bound to the top level.
// Depends on vss_pkg and vector_similarity_scorer.
`timescale 1ns / 1ps

module vss_checker (
  input logic                       clk,
  input logic                       rst_n,
  input logic                       in_valid,
  input logic                       in_stall,
  input logic                       out_valid,
  input logic                       out_stall,
  input vss_pkg::out_word_t         out_word,
  input logic                       pready
);
  import vss_pkg::*;

  // result word is held while stalled
  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_stall |=> out_valid && $stable(out_word))
    else $error("result word dropped or changed under stall");

  // input backpressure only comes from a waiting, stalled result
  a_in_stall_src: assert property (@(posedge clk) disable iff (!rst_n)
    in_stall |-> out_valid && out_stall)
    else $error("input stalled without a stalled result");

  // a free output register never blocks input
  a_no_idle_stall: assert property (@(posedge clk) disable iff (!rst_n)
    !out_valid |-> !in_stall)
    else $error("input stalled while output register empty");

  // a new result needs an accepted input word the pipeline depth back, unless the output stalled in between
  a_min_latency: assert property (@(posedge clk) disable iff (!rst_n)
    $rose(out_valid) |-> $past(in_valid && !in_stall, 3) || $past(out_stall, 1)
                         || $past(out_stall, 2) || $past(out_stall, 3))
    else $error("result word without a row element three cycles back");

  a_pready: assert property (@(posedge clk) disable iff (!rst_n) pready)
    else $error("pready low");

endmodule

bind vector_similarity_scorer vss_checker u_vss_checker (.*);
